[src/assert_macros.svh]
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define STPR_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[src/stpr_pkg.sv]
// Types, constants and the tag table of the sensor tag record parser.
package stpr_pkg;

  localparam int TABLE_SIZE = 17;
  localparam int ENTRY_W    = 5;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [7:0] TERM_RESET = 8'hFF;

  localparam logic [1:0] KIND_FLOAT = 2'd0;
  localparam logic [1:0] KIND_ARRAY = 2'd1;
  localparam logic [1:0] KIND_BOOL  = 2'd2;
  localparam logic [1:0] KIND_CHAR  = 2'd3;

  localparam logic [1:0] LAST_WORD = 2'd3;
  localparam logic [1:0] LAST_BYTE = 2'd3;

  typedef enum logic [1:0] {
    OP_SHIFT,
    OP_EMIT,
    OP_END
  } op_t;

  // One queued operation for the back end.
  typedef struct packed {
    op_t                op;
    logic [7:0]         data;
    logic [ENTRY_W-1:0] entry;
    logic [1:0]         word_idx;
    logic               last;
  } q_op_t;

  function automatic logic [7:0] tag_of(input logic [ENTRY_W-1:0] e);
    logic [7:0] t;
    case (e)
      5'd0:    t = 8'd5;
      5'd1:    t = 8'd24;
      5'd2:    t = 8'd25;
      5'd3:    t = 8'd79;
      5'd4:    t = 8'd77;
      5'd5:    t = 8'd7;
      5'd6:    t = 8'd8;
      5'd7:    t = 8'd9;
      5'd8:    t = 8'd21;
      5'd9:    t = 8'd22;
      5'd10:   t = 8'd23;
      5'd11:   t = 8'd27;
      5'd12:   t = 8'd28;
      5'd13:   t = 8'd29;
      5'd14:   t = 8'd74;
      5'd15:   t = 8'd75;
      5'd16:   t = 8'd76;
      default: t = 8'd5;
    endcase
    return t;
  endfunction

  function automatic logic [1:0] kind_of(input logic [ENTRY_W-1:0] e);
    logic [1:0] k;
    case (e)
      5'd3:    k = KIND_CHAR;
      5'd4:    k = KIND_ARRAY;
      5'd6:    k = KIND_BOOL;
      5'd7:    k = KIND_BOOL;
      default: k = KIND_FLOAT;
    endcase
    return k;
  endfunction

endpackage

[src/stpr_front.sv]
// Front end: accepts bytes, tracks tag/payload position and queues operations.
`include "assert_macros.svh"

module stpr_front #(
  parameter int NUM_TAGS = 17
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic [7:0]         in_data_byte,
  input  logic               q_full,
  output logic               push,
  output stpr_pkg::q_op_t    push_op
);

  localparam int LIMIT = (NUM_TAGS < stpr_pkg::TABLE_SIZE) ? NUM_TAGS : stpr_pkg::TABLE_SIZE;

  logic [7:0]                          term_r;
  logic                                in_payload_r, in_payload_nxt;
  logic [stpr_pkg::ENTRY_W-1:0]        entry_r, entry_nxt;
  logic [1:0]                          byte_cnt_r, byte_cnt_nxt;
  logic [1:0]                          word_cnt_r, word_cnt_nxt;
  logic [stpr_pkg::TABLE_SIZE-1:0]     seen_r, seen_nxt;

  logic                                accept;
  logic                                hit;
  logic [stpr_pkg::ENTRY_W-1:0]        hit_idx;
  logic [1:0]                          cur_kind;

  assign accept   = in_valid && !q_full;
  assign cur_kind = stpr_pkg::kind_of(entry_r);

  // Lowest unseen table entry whose tag matches the byte.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = stpr_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
      if (i < LIMIT && !seen_r[i] &&
          stpr_pkg::tag_of(stpr_pkg::ENTRY_W'(i)) == in_data_byte) begin
        hit     = 1'b1;
        hit_idx = stpr_pkg::ENTRY_W'(i);
      end
    end
  end

  always_comb begin
    in_payload_nxt   = in_payload_r;
    entry_nxt        = entry_r;
    byte_cnt_nxt     = byte_cnt_r;
    word_cnt_nxt     = word_cnt_r;
    seen_nxt         = seen_r;
    push             = 1'b0;
    push_op.op       = stpr_pkg::OP_SHIFT;
    push_op.data     = in_data_byte;
    push_op.entry    = entry_r;
    push_op.word_idx = '0;
    push_op.last     = 1'b0;
    if (accept) begin
      if (in_data_byte == term_r) begin
        push           = 1'b1;
        push_op.op     = stpr_pkg::OP_END;
        in_payload_nxt = 1'b0;
        entry_nxt      = '0;
        byte_cnt_nxt   = '0;
        word_cnt_nxt   = '0;
        seen_nxt       = '0;
      end else if (!in_payload_r) begin
        if (hit) begin
          seen_nxt[hit_idx] = 1'b1;
          entry_nxt         = hit_idx;
          in_payload_nxt    = 1'b1;
          byte_cnt_nxt      = '0;
          word_cnt_nxt      = '0;
        end
      end else if (cur_kind == stpr_pkg::KIND_BOOL || cur_kind == stpr_pkg::KIND_CHAR) begin
        push           = 1'b1;
        push_op.op     = stpr_pkg::OP_EMIT;
        push_op.last   = 1'b1;
        in_payload_nxt = 1'b0;
      end else if (byte_cnt_r != stpr_pkg::LAST_BYTE) begin
        push         = 1'b1;
        byte_cnt_nxt = byte_cnt_r + 2'd1;
      end else begin
        push         = 1'b1;
        push_op.op   = stpr_pkg::OP_EMIT;
        byte_cnt_nxt = '0;
        if (cur_kind == stpr_pkg::KIND_ARRAY) begin
          push_op.word_idx = word_cnt_r;
          push_op.last     = (word_cnt_r == stpr_pkg::LAST_WORD);
        end else begin
          push_op.last = 1'b1;
        end
        if (push_op.last) begin
          in_payload_nxt = 1'b0;
          word_cnt_nxt   = '0;
        end else begin
          word_cnt_nxt = word_cnt_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r       <= stpr_pkg::TERM_RESET;
      in_payload_r <= 1'b0;
      entry_r      <= '0;
      byte_cnt_r   <= '0;
      word_cnt_r   <= '0;
      seen_r       <= '0;
    end else begin
      if (cfg_we) begin
        term_r <= cfg_wdata;
      end
      in_payload_r <= in_payload_nxt;
      entry_r      <= entry_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      word_cnt_r   <= word_cnt_nxt;
      seen_r       <= seen_nxt;
    end
  end

  `STPR_ASSERT(a_cnt_in_word_field, (byte_cnt_r == 2'd0) || (in_payload_r && (cur_kind == stpr_pkg::KIND_FLOAT || cur_kind == stpr_pkg::KIND_ARRAY)), "byte count set outside a float payload")
  `STPR_ASSERT(a_entry_in_table, !in_payload_r || (entry_r < stpr_pkg::ENTRY_W'(LIMIT)), "payload entry outside the matched range")

endmodule

[src/stpr_queue.sv]
// Short operation queue between the front and back ends.
`include "assert_macros.svh"

module stpr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stpr_pkg::q_op_t push_op,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output stpr_pkg::q_op_t head_op
);

  stpr_pkg::q_op_t                mem_r [stpr_pkg::QDEPTH];
  logic [stpr_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [stpr_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [stpr_pkg::QCNT_W-1:0]    count_r;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == stpr_pkg::QCNT_W'(stpr_pkg::QDEPTH));
  assign head_op = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + stpr_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + stpr_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + stpr_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - stpr_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  `STPR_ASSERT(a_no_overflow, !(push && q_full), "push into a full queue")
  `STPR_ASSERT(a_no_underflow, !(pop && !q_valid), "pop from an empty queue")

endmodule

[src/stpr_back.sv]
// Back end: assembles payload words and drives the result register.
`include "assert_macros.svh"

module stpr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  stpr_pkg::q_op_t head_op,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [7:0]      out_tag_id,
  output logic [31:0]     out_value_bits,
  output logic [1:0]      out_value_kind,
  output logic [1:0]      out_word_index,
  output logic            out_last_of_field,
  output logic            out_packet_end
);

  logic [23:0] asm_r, asm_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        load;
  logic [7:0]  tag_nxt;
  logic [31:0] value_nxt;
  logic [1:0]  kind_nxt;
  logic [1:0]  idx_nxt;
  logic        last_nxt;
  logic        end_nxt;
  logic [7:0]  tag_r;
  logic [31:0] value_r;
  logic [1:0]  kind_r;
  logic [1:0]  idx_r;
  logic        last_r;
  logic        end_r;
  logic        slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  // Shift operations never produce a result, so take them regardless of the output.
  assign pop  = q_valid && (head_op.op == stpr_pkg::OP_SHIFT || slot_free);
  assign load = pop && head_op.op != stpr_pkg::OP_SHIFT;

  always_comb begin
    asm_nxt   = asm_r;
    tag_nxt   = '0;
    value_nxt = '0;
    kind_nxt  = '0;
    idx_nxt   = '0;
    last_nxt  = 1'b0;
    end_nxt   = 1'b0;
    if (pop) begin
      case (head_op.op)
        stpr_pkg::OP_SHIFT: begin
          asm_nxt = {asm_r[15:0], head_op.data};
        end
        stpr_pkg::OP_EMIT: begin
          asm_nxt  = '0;
          tag_nxt  = stpr_pkg::tag_of(head_op.entry);
          kind_nxt = stpr_pkg::kind_of(head_op.entry);
          idx_nxt  = head_op.word_idx;
          last_nxt = head_op.last;
          case (kind_nxt)
            stpr_pkg::KIND_BOOL: value_nxt = {31'd0, head_op.data == 8'd1};
            stpr_pkg::KIND_CHAR: value_nxt = {24'd0, head_op.data};
            default:             value_nxt = {asm_r, head_op.data};
          endcase
        end
        stpr_pkg::OP_END: begin
          asm_nxt = '0;
          end_nxt = 1'b1;
        end
        default: begin
          asm_nxt = asm_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      asm_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      asm_r       <= asm_nxt;
    end
  end

  // Hold the result payload until a new one is loaded.
  always_ff @(posedge clk) begin
    if (load) begin
      tag_r   <= tag_nxt;
      value_r <= value_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
      end_r   <= end_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tag_id        = tag_r;
  assign out_value_bits    = value_r;
  assign out_value_kind    = kind_r;
  assign out_word_index    = idx_r;
  assign out_last_of_field = last_r;
  assign out_packet_end    = end_r;

  `STPR_ASSERT_NEXT(a_load_shows, load, out_valid_r, "loaded result not presented")
  `STPR_ASSERT(a_no_overwrite, !(load && out_valid_r && out_stall), "result overwritten while stalled")

endmodule

[src/sensor_tag_record_parser.sv]
// Top level of the sensor tag record parser.
//
//   channel  direction  ports                            transaction
//   in       input      in_valid, in_stall, in_data_byte one packet byte
//   out      output     out_valid, out_stall, out_*      one decoded field word or packet end
//   cfg      input      cfg_we, cfg_wdata                terminator byte write
//
// One byte per cycle while in_stall is low; the front end classifies each byte in the cycle it is taken.
// With an empty queue, the byte that completes a result is queued, then popped into the result register and out_valid.
// Reset is synchronous; no clearing pass, the block takes bytes as soon as reset is released.
// A four-entry operation queue lets output stalls back up without losing bytes;
// in_stall rises only when that queue is full.

module sensor_tag_record_parser #(
  parameter int NUM_TAGS = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tag_id,
  output logic [31:0] out_value_bits,
  output logic [1:0]  out_value_kind,
  output logic [1:0]  out_word_index,
  output logic        out_last_of_field,
  output logic        out_packet_end
);

  logic            push;
  stpr_pkg::q_op_t push_op;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  stpr_pkg::q_op_t head_op;

  assign in_stall = q_full;

  stpr_front #(
    .NUM_TAGS (NUM_TAGS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  stpr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .head_op (head_op)
  );

  stpr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .head_op           (head_op),
    .pop               (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_tag_id        (out_tag_id),
    .out_value_bits    (out_value_bits),
    .out_value_kind    (out_value_kind),
    .out_word_index    (out_word_index),
    .out_last_of_field (out_last_of_field),
    .out_packet_end    (out_packet_end)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the sensor tag record parser.
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_ENTRIES = stpr_pkg::TABLE_SIZE;
  localparam int LIMIT       = 400000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 90;
  localparam int SETTLE      = 20;

  // Known tags, entry 0 in the low byte.
  localparam logic [NUM_ENTRIES*8-1:0] TAG_CODES = {
    8'd76, 8'd75, 8'd74, 8'd29, 8'd28, 8'd27, 8'd23, 8'd22, 8'd21,
    8'd9, 8'd8, 8'd7, 8'd77, 8'd79, 8'd25, 8'd24, 8'd5
  };
  localparam logic [NUM_ENTRIES*2-1:0] TAG_KINDS = {
    {9{stpr_pkg::KIND_FLOAT}}, stpr_pkg::KIND_BOOL, stpr_pkg::KIND_BOOL,
    stpr_pkg::KIND_FLOAT, stpr_pkg::KIND_ARRAY, stpr_pkg::KIND_CHAR,
    {3{stpr_pkg::KIND_FLOAT}}
  };

  localparam int E_FLOAT   = 0;
  localparam int E_CHAR    = 3;
  localparam int E_QUAT    = 4;
  localparam int E_FLOAT_7 = 5;
  localparam int E_BOOL_A  = 6;
  localparam int E_BOOL_B  = 7;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] value;
    logic [1:0]  kind;
    logic [1:0]  index;
    logic        last;
    logic        pend;
  } field_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_tag_id;
  logic [31:0] out_value_bits;
  logic [1:0]  out_value_kind;
  logic [1:0]  out_word_index;
  logic        out_last_of_field;
  logic        out_packet_end;

  // Parser state mirrored by the predictor.
  logic [7:0]             term_byte = stpr_pkg::TERM_RESET;
  logic                   in_field = 1'b0;
  int                     cur_entry = 0;
  logic [1:0]             byte_cnt = 2'd0;
  logic [1:0]             word_cnt = 2'd0;
  logic [23:0]            acc = 24'd0;
  logic [NUM_ENTRIES-1:0] seen = '0;

  logic [7:0]  byte_queue [$];
  field_word_t pending_fields [$];
  field_word_t want;

  int bytes_queued = 0;
  int bytes_taken = 0;
  int src_odds = 15;
  int snk_odds = 15;
  int src_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int words_checked = 0;
  int ends_checked = 0;
  int errors = 0;
  int cycle_count = 0;

  sensor_tag_record_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tag_id        (out_tag_id),
    .out_value_bits    (out_value_bits),
    .out_value_kind    (out_value_kind),
    .out_word_index    (out_word_index),
    .out_last_of_field (out_last_of_field),
    .out_packet_end    (out_packet_end)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] tag_at(input int e);
    return TAG_CODES[e*8 +: 8];
  endfunction

  // Advance the expected parser state by one byte; queue any field word or packet end it completes.
  function automatic void advance_parser(input logic [7:0] b);
    logic [1:0]  kd;
    bit          hit;
    field_word_t r;
    r = '0;
    if (b == term_byte) begin
      in_field = 1'b0;
      cur_entry = 0;
      byte_cnt = 2'd0;
      word_cnt = 2'd0;
      acc = 24'd0;
      seen = '0;
      r.pend = 1'b1;
      pending_fields.push_back(r);
      return;
    end
    if (!in_field) begin
      hit = 1'b0;
      for (int i = 0; i < NUM_ENTRIES && !hit; i++) begin
        if (tag_at(i) == b && !seen[i]) begin
          seen[i] = 1'b1;
          cur_entry = i;
          in_field = 1'b1;
          byte_cnt = 2'd0;
          word_cnt = 2'd0;
          acc = 24'd0;
          hit = 1'b1;
        end
      end
      return;
    end
    kd = TAG_KINDS[cur_entry*2 +: 2];
    r.tag = tag_at(cur_entry);
    r.kind = kd;
    if (kd == stpr_pkg::KIND_BOOL || kd == stpr_pkg::KIND_CHAR) begin
      in_field = 1'b0;
      r.value = (kd == stpr_pkg::KIND_BOOL) ? {31'd0, b == 8'd1} : {24'd0, b};
      r.last = 1'b1;
      pending_fields.push_back(r);
      return;
    end
    if (byte_cnt != stpr_pkg::LAST_BYTE) begin
      acc = {acc[15:0], b};
      byte_cnt = byte_cnt + 2'd1;
      return;
    end
    r.value = {acc, b};
    r.index = (kd == stpr_pkg::KIND_ARRAY) ? word_cnt : 2'd0;
    r.last = (kd != stpr_pkg::KIND_ARRAY) || (r.index == stpr_pkg::LAST_WORD);
    byte_cnt = 2'd0;
    acc = 24'd0;
    if (r.last) begin
      in_field = 1'b0;
      word_cnt = 2'd0;
    end else begin
      word_cnt = word_cnt + 2'd1;
    end
    pending_fields.push_back(r);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch: %s at cycle %0d, got 0x%0h, expected 0x%0h", what, cycle_count, got, exp);
    errors++;
  endtask

  // Byte driver: take a transaction when it is accepted, hold while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_parser(in_data_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap == 0 && src_odds != 0 && $urandom_range(1, 100) <= src_odds)
          src_gap = $urandom_range(1, 13);
        if (src_gap != 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          in_data_byte <= byte_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold off once for a long stretch so the input side backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and output stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_fields.size() == 0) begin
          report("result with nothing expected, tag_id", 32'(out_tag_id), 32'd0);
        end else begin
          want = pending_fields.pop_front();
          if (out_tag_id !== want.tag) report("tag_id", 32'(out_tag_id), 32'(want.tag));
          if (out_value_bits !== want.value) report("value_bits", out_value_bits, want.value);
          if (out_value_kind !== want.kind)
            report("value_kind", 32'(out_value_kind), 32'(want.kind));
          if (out_word_index !== want.index)
            report("word_index", 32'(out_word_index), 32'(want.index));
          if (out_last_of_field !== want.last)
            report("last_of_field", 32'(out_last_of_field), 32'(want.last));
          if (out_packet_end !== want.pend)
            report("packet_end", 32'(out_packet_end), 32'(want.pend));
          if (want.pend) ends_checked++;
          else words_checked++;
        end
      end
      if (stall_left == 0 && snk_odds != 0 && $urandom_range(1, 100) <= snk_odds)
        stall_left = $urandom_range(1, 13);
      out_stall <= (stall_left != 0) || (hold_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_fields.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_queue.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    while (v == term_byte) v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  // Queue one packet of random fields; cut the last payload short when asked.
  task automatic queue_packet(input int n_fields, input bit cut_short);
    int         e;
    int         len;
    logic [1:0] kd;
    for (int f = 0; f < n_fields; f++) begin
      if ($urandom_range(0, 9) == 0) push_byte(payload_byte());
      e = $urandom_range(0, NUM_ENTRIES - 1);
      kd = TAG_KINDS[e*2 +: 2];
      push_byte(tag_at(e));
      len = (kd == stpr_pkg::KIND_ARRAY) ? 16 : (kd == stpr_pkg::KIND_FLOAT) ? 4 : 1;
      if (cut_short && f == n_fields - 1) len = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
        if (kd == stpr_pkg::KIND_BOOL && $urandom_range(0, 1) == 1) push_byte(8'd1);
        else push_byte(payload_byte());
      end
    end
    push_byte(term_byte);
  endtask

  task automatic queue_random(input int n_bytes);
    int start;
    int r;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        queue_packet($urandom_range(1, 6), 1'b0);
      end else if (r < 9) begin
        queue_packet($urandom_range(1, 4), 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Wait for every byte to be taken and every result to arrive, then let the pipe settle.
  task automatic drain();
    while (byte_queue.size() != 0 || in_valid || pending_fields.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_terminator(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    term_byte = v;
    @(negedge clk);
  endtask

  initial begin : main
    logic [7:0] rand_term;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset terminator: every kind, repeat tag, unknown tag, terminator inside the quaternion.
    push_byte(8'h00);
    push_byte(tag_at(E_BOOL_A)); push_byte(8'h01);
    push_byte(tag_at(E_BOOL_B)); push_byte(8'hFE);
    push_byte(tag_at(E_CHAR));   push_byte(8'h00);
    push_byte(tag_at(E_FLOAT));
    push_byte(8'h80); push_byte(8'h00); push_byte(8'h00); push_byte(8'h01);
    push_byte(tag_at(E_BOOL_A)); push_byte(8'h55);
    push_byte(tag_at(E_QUAT));
    push_byte(8'h3F); push_byte(8'h80); push_byte(8'h00); push_byte(8'h00); push_byte(8'h12);
    push_byte(stpr_pkg::TERM_RESET); push_byte(stpr_pkg::TERM_RESET);
    queue_random(230);
    drain();

    // Zero terminator; 0xFF becomes ordinary data.
    src_odds = 10;
    snk_odds = 25;
    set_terminator(8'h00);
    push_byte(tag_at(E_CHAR)); push_byte(8'hFF);
    push_byte(tag_at(E_BOOL_A)); push_byte(8'h00);
    queue_random(200);
    drain();

    // Terminator that is also a known tag.
    src_odds = 25;
    snk_odds = 0;
    set_terminator(tag_at(E_FLOAT_7));
    push_byte(tag_at(E_FLOAT_7));
    push_byte(tag_at(E_FLOAT));
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h12); push_byte(8'h34);
    push_byte(tag_at(E_BOOL_A)); push_byte(tag_at(E_FLOAT_7));
    queue_random(190);
    drain();

    src_odds = 0;
    snk_odds = 30;
    rand_term = 8'($urandom_range(0, 255));
    set_terminator(rand_term);
    queue_random(150);
    drain();

    // Back to 0xFF with both sides running flat out.
    src_odds = 0;
    snk_odds = 0;
    set_terminator(8'hFF);
    queue_random(110);
    drain();

    $display("parsed %0d bytes: %0d field words and %0d packet ends matched the prediction",
             bytes_taken, words_checked, ends_checked);
    $display("terminators 0xFF, 0x00, tag 0x%02h and 0x%02h; one long output hold-off",
             tag_at(E_FLOAT_7), rand_term);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
